[src/b64se_pkg.sv]
// Package for the base64 stream encoder: group entry and status types,
// the pad code and the sextet-to-ASCII mapping. No dependencies.
package b64se_pkg;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam int         QUEUE_DEPTH = 2;
  localparam int         QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int         QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] HELD_ONE   = 2'd1;
  localparam logic [1:0] HELD_TWO   = 2'd2;
  localparam logic [1:0] HELD_THREE = 2'd3;
  localparam logic [1:0] LAST_CHAR  = 2'd3;

  typedef struct packed {
    logic [23:0] group;
    logic [1:0]  held;
    logic        fin;
  } grp_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] c;
    case (v) inside
      [6'd0:6'd25]:  c = 8'h41 + {2'b00, v};
      [6'd26:6'd51]: c = 8'h61 + {2'b00, v} - 8'd26;
      [6'd52:6'd61]: c = 8'h30 + {2'b00, v} - 8'd52;
      6'd62:         c = 8'h2B;
      default:       c = 8'h2F;
    endcase
    return c;
  endfunction

endpackage

[src/b64se_front.sv]
// Front end: accepts raw bytes, gathers the open group and pushes
// complete or final groups into the queue. Uses b64se_pkg.
module b64se_front import b64se_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_final_byte,
  input  queue_stat_t q_stat,
  output logic        push,
  output grp_t        push_grp
);

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] pend0_r, pend0_nxt;
  logic [7:0] pend1_r, pend1_nxt;
  logic [1:0] phase_eff;
  logic [1:0] held;
  logic       xfer;

  assign in_ready = !q_stat.full;
  assign xfer     = in_valid && in_ready;

  always_comb begin
    phase_eff = (phase_r == 2'd3) ? 2'd2 : phase_r;
    pend0_nxt = pend0_r;
    pend1_nxt = pend1_r;
    phase_nxt = phase_r;
    push      = 1'b0;
    held      = (phase_eff == 2'd2) ? HELD_THREE : phase_eff + 2'd1;
    push_grp  = '0;
    if (xfer) begin
      if (phase_eff == 2'd0) pend0_nxt = in_data_byte;
      if (phase_eff == 2'd1) pend1_nxt = in_data_byte;
      if (held != HELD_THREE && !in_final_byte) begin
        phase_nxt = held;
      end else begin
        push                 = 1'b1;
        push_grp.group[23:16] = pend0_nxt;
        push_grp.group[15:8]  = (held != HELD_ONE) ? pend1_nxt : 8'h00;
        push_grp.group[7:0]   = (held == HELD_THREE) ? in_data_byte : 8'h00;
        push_grp.held        = held;
        push_grp.fin         = in_final_byte;
        pend0_nxt            = 8'h00;
        pend1_nxt            = 8'h00;
        phase_nxt            = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
      pend0_r <= 8'h00;
      pend1_r <= 8'h00;
    end else begin
      phase_r <= phase_nxt;
      pend0_r <= pend0_nxt;
      pend1_r <= pend1_nxt;
    end
  end

endmodule

[src/b64se_queue.sv]
// Short group queue between front and back ends, register based.
// Uses b64se_pkg for the entry type and depth.
module b64se_queue import b64se_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  grp_t        push_grp,
  input  logic        pop,
  output grp_t        pop_grp,
  output queue_stat_t q_stat
);

  grp_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign pop_grp      = mem_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (cnt_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[src/b64se_back.sv]
// Back end: takes one group from the queue and emits its four characters
// through an output register, one per transfer. Uses b64se_pkg.
module b64se_back import b64se_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  queue_stat_t q_stat,
  input  grp_t        pop_grp,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_code_char,
  output logic        out_run_last,
  output logic        out_message_end
);

  grp_t       cur_r, cur_nxt;
  logic       busy_r, busy_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] char_r, char_nxt;
  logic       rlast_r, rlast_nxt;
  logic       mend_r, mend_nxt;
  logic       emit;
  logic [5:0] sext;
  logic [7:0] dchar;

  always_comb begin
    case (idx_r)
      2'd0:    sext = cur_r.group[23:18];
      2'd1:    sext = cur_r.group[17:12];
      2'd2:    sext = cur_r.group[11:6];
      default: sext = cur_r.group[5:0];
    endcase
    dchar = sextet_char(sext);
  end

  always_comb begin
    emit      = busy_r && (!ov_r || out_ready);
    pop       = !q_stat.empty && (!busy_r || (emit && idx_r == LAST_CHAR));
    cur_nxt   = cur_r;
    busy_nxt  = busy_r;
    idx_nxt   = idx_r;
    ov_nxt    = ov_r;
    char_nxt  = char_r;
    rlast_nxt = rlast_r;
    mend_nxt  = mend_r;
    if (emit) begin
      ov_nxt    = 1'b1;
      rlast_nxt = (idx_r == LAST_CHAR);
      mend_nxt  = (idx_r == LAST_CHAR) && cur_r.fin;
      if (idx_r == 2'd2 && cur_r.held == HELD_ONE) char_nxt = PAD_CHAR;
      else if (idx_r == LAST_CHAR && cur_r.held != HELD_THREE) char_nxt = PAD_CHAR;
      else char_nxt = dchar;
      idx_nxt = idx_r + 2'd1;
      if (idx_r == LAST_CHAR) busy_nxt = 1'b0;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
    if (pop) begin
      cur_nxt  = pop_grp;
      busy_nxt = 1'b1;
      idx_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    char_r  <= char_nxt;
    rlast_r <= rlast_nxt;
    mend_r  <= mend_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      ov_r   <= ov_nxt;
    end
  end

  assign out_valid       = ov_r;
  assign out_code_char   = char_r;
  assign out_run_last    = rlast_r;
  assign out_message_end = mend_r;

endmodule

[src/base64_stream_encoder.sv]
// Base64 stream encoder, standard alphabet with '=' padding.
// Channels: input in_valid/in_ready carries one raw byte (in_data_byte)
//   and in_final_byte, set on the last byte of a message.
// Output out_valid/out_ready carries one ASCII character per transfer,
//   with out_run_last on the fourth character of a group and
//   out_message_end on the fourth character of the message's last group.
// Every third byte, or a final byte, closes a group of four characters;
//   a short final group is zero-filled and padded with '='.
// A group closed by a byte is pushed into the queue, then popped into
//   the back end's group register; each of its characters is registered
//   in the output register before it is shown.
// Bytes are taken one per cycle while the two-entry group queue has
//   room; the back end emits one character per cycle while the receiver
//   takes them, four characters per group.
// Reset (rst_n low, synchronous) empties the queue, drops any open group
//   and clears the output valid flag.
// When the receiver stalls, the current character holds in the output
//   register; the queue fills and in_ready drops once two groups wait.
module base64_stream_encoder import b64se_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_final_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_code_char,
  output logic       out_run_last,
  output logic       out_message_end
);

  queue_stat_t q_stat;
  logic        push;
  logic        pop;
  grp_t        push_grp;
  grp_t        pop_grp;

  b64se_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_final_byte (in_final_byte),
    .q_stat        (q_stat),
    .push          (push),
    .push_grp      (push_grp)
  );

  b64se_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_grp (push_grp),
    .pop      (pop),
    .pop_grp  (pop_grp),
    .q_stat   (q_stat)
  );

  b64se_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .pop_grp         (pop_grp),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_code_char   (out_code_char),
    .out_run_last    (out_run_last),
    .out_message_end (out_message_end)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_stat.full && !pop))
    else $error("group queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && q_stat.empty))
    else $error("group queue underflow");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_message_end |-> out_run_last)
    else $error("message end off a group boundary");

  a_pad_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_code_char == PAD_CHAR && !out_run_last |-> !out_message_end)
    else $error("pad character with end mark before group end");

endmodule
